@@ hdl/empr_pkg.sv @@
// ----------------------------------------------------------------------------
// empr_pkg
// Shared types and codes of the extent map page resolver: item and result
// payloads, status and action codes, register indexes and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package empr_pkg;

  // status codes of a result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // action codes of an input item
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE       = 2'd2;

  // reset values of the configuration registers
  localparam logic [6:0]  MAP_COUNT_RST  = 7'd0;
  localparam logic [31:0] TERMINATOR_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] HOLE_RST       = 32'hFFFF_FFFE;

  typedef struct packed {
    logic        action;
    logic [5:0]  entry_index;
    logic [31:0] entry_start_page;
    logic [31:0] entry_disk_block;
    logic [31:0] page_num;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] volume_page;
  } result_t;

  // source of the result register
  typedef enum logic [1:0] {
    RK_ACK,
    RK_MISS,
    RK_RESERVED,
    RK_CALC
  } res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;
    logic      mem_write;
    logic      scan_step;
    logic      sel_prev;
    logic      sel_cur;
    logic      res_load;
    res_kind_t res_kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_is_write;
    logic item_page_zero;
    logic cnt_zero;
    logic pair_hit;
    logic cur_ge;
    logic cur_term;
    logic is_last;
  } dp_status_t;

endpackage

@@ hdl/empr_ctrl.sv @@
// ----------------------------------------------------------------------------
// empr_ctrl
// Controller of the resolver: accepts items, steps the entry scan, runs the
// three arithmetic stages and strobes each result for one cycle.
// ----------------------------------------------------------------------------
module empr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  empr_pkg::dp_status_t stat,
  output empr_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_C1,
    S_C2,
    S_C3,
    S_OUT
  } state_t;

  state_t state, state_next;

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_kind = empr_pkg::RK_MISS;
    case (state)
      S_IDLE, S_OUT: begin
        state_next = S_IDLE;
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.item_is_write) begin
            cmd.mem_write = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.res_kind  = empr_pkg::RK_ACK;
            state_next    = S_OUT;
          end else if (stat.cnt_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = stat.item_page_zero ? empr_pkg::RK_RESERVED : empr_pkg::RK_MISS;
            state_next   = S_OUT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.pair_hit) begin
          cmd.sel_prev = 1'b1;
          state_next   = S_C1;
        end else if (stat.is_last) begin
          if (stat.cur_ge && !stat.cur_term) begin
            cmd.sel_cur = 1'b1;
            state_next  = S_C1;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_kind = empr_pkg::RK_MISS;
            state_next   = S_OUT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_C1: state_next = S_C2;
      S_C2: state_next = S_C3;
      S_C3: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = empr_pkg::RK_CALC;
        state_next   = S_OUT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= !(state_next == S_IDLE || state_next == S_OUT);
      done  <= (state_next == S_OUT);
    end
  end

endmodule

@@ hdl/empr_dpath.sv @@
// ----------------------------------------------------------------------------
// empr_dpath
// Datapath of the resolver: configuration registers, the entry memory with
// its scan pointer and compare logic, the block arithmetic stages and the
// result register.
// ----------------------------------------------------------------------------
module empr_dpath #(
  parameter int unsigned TABLE_DEPTH     = 64,
  parameter int unsigned BLOCKS_PER_PAGE = 16,
  parameter int unsigned RESERVED_BLOCKS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  empr_pkg::item_t                     item,
  input  logic                                cfg_valid,
  input  logic [empr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  input  empr_pkg::ctrl_cmd_t                 cmd,
  output empr_pkg::dp_status_t                stat,
  output empr_pkg::result_t                   result
);

  localparam int unsigned IDXW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW      = ($clog2(TABLE_DEPTH + 1) > 7) ? $clog2(TABLE_DEPTH + 1) : 7;
  localparam int unsigned LOG_BPP = $clog2(BLOCKS_PER_PAGE);
  localparam int unsigned K       = 32 + LOG_BPP;
  localparam int unsigned PRODW   = K + 32;
  // reciprocal of the page size, low by at most one unit of the quotient
  localparam logic [PRODW-1:0] RECIP = (PRODW'(1) << K) / BLOCKS_PER_PAGE;
  localparam logic [31:0] BPP32    = 32'(BLOCKS_PER_PAGE);
  localparam logic [31:0] RES_PAGE = 32'(RESERVED_BLOCKS / BLOCKS_PER_PAGE);

  typedef struct packed {
    logic [31:0] start_page;
    logic [31:0] base_block;
  } entry_t;

  // configuration registers
  logic [6:0]  map_count;
  logic [31:0] terminator_marker;
  logic [31:0] hole_marker;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_count         <= empr_pkg::MAP_COUNT_RST;
      terminator_marker <= empr_pkg::TERMINATOR_RST;
      hole_marker       <= empr_pkg::HOLE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        empr_pkg::REG_MAP_COUNT:  map_count         <= cfg_data[6:0];
        empr_pkg::REG_TERMINATOR: terminator_marker <= cfg_data;
        empr_pkg::REG_HOLE:       hole_marker       <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry count clamped to the table depth
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] last_slot;
  assign cnt_eff   = (CW'(map_count) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(map_count);
  assign last_slot = cnt_eff - CW'(1);

  // entry memory, one write and one registered read per cycle
  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_entry;
  logic [IDXW-1:0] rd_ptr;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] wr_addr;
  logic [31:0]     wr_idx32;
  logic            wr_in_range;

  assign wr_idx32    = 32'(item.entry_index);
  assign wr_in_range = wr_idx32 < 32'(TABLE_DEPTH);
  assign wr_addr     = wr_idx32[IDXW-1:0];
  assign rd_addr     = cmd.accept ? '0 : rd_ptr;

  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_in_range) begin
      mem[wr_addr] <= '{start_page: item.entry_start_page, base_block: item.entry_disk_block};
    end
    rd_entry <= mem[rd_addr];
  end

  // scan registers: looked-up page, previous entry and its compare
  logic [31:0]     page;
  logic [IDXW-1:0] slot;
  logic [31:0]     prev_start;
  logic [31:0]     prev_block;
  logic            prev_ge;
  logic            cur_ge;

  assign cur_ge = page >= rd_entry.start_page;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page    <= item.page_num;
      rd_ptr  <= IDXW'(1);
      slot    <= '0;
      prev_ge <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_ptr     <= rd_ptr + IDXW'(1);
      slot       <= slot + IDXW'(1);
      prev_start <= rd_entry.start_page;
      prev_block <= rd_entry.base_block;
      prev_ge    <= cur_ge;
    end
  end

  // status back to the controller
  always_comb begin
    stat.item_is_write  = (item.action == empr_pkg::ACT_WRITE);
    stat.item_page_zero = (item.page_num == 32'd0);
    stat.cnt_zero       = (cnt_eff == '0);
    stat.pair_hit       = prev_ge && (page < rd_entry.start_page);
    stat.cur_ge         = cur_ge;
    stat.cur_term       = (rd_entry.base_block == terminator_marker);
    stat.is_last        = (CW'(slot) == last_slot);
  end

  // selected entry
  logic [31:0] sel_start;
  logic [31:0] sel_block;

  always_ff @(posedge clk) begin
    if (cmd.sel_prev) begin
      sel_start <= prev_start;
      sel_block <= prev_block;
    end else if (cmd.sel_cur) begin
      sel_start <= rd_entry.start_page;
      sel_block <= rd_entry.base_block;
    end
  end

  // stage 1: page offset, marker check, reciprocal product of the block
  logic [31:0]      off1;
  logic [31:0]      blk1;
  logic             miss1;
  logic [PRODW-1:0] prod1;

  always_ff @(posedge clk) begin
    off1  <= page - sel_start;
    blk1  <= sel_block;
    miss1 <= (sel_block == terminator_marker) || (sel_block == hole_marker);
    prod1 <= PRODW'(sel_block) * RECIP;
  end

  // stage 2: quotient estimate and its remainder, range of the disk block
  logic [31:0] est_c;
  logic [31:0] est_prod;
  logic [63:0] disk;
  logic [31:0] est2;
  logic [31:0] rem2;
  logic        range2;
  logic [31:0] off2;
  logic        miss2;

  assign est_c    = prod1[K +: 32];
  assign est_prod = 32'(64'(est_c) * 64'(BLOCKS_PER_PAGE));
  assign disk     = 64'(off1) * 64'(BLOCKS_PER_PAGE) + 64'(blk1);

  always_ff @(posedge clk) begin
    est2   <= est_c;
    rem2   <= blk1 - est_prod;
    range2 <= (disk[63:32] != 32'd0);
    off2   <= off1;
    miss2  <= miss1;
  end

  // stage 3: corrected quotient plus page offset
  logic [31:0] quot;
  logic [31:0] calc_page;

  assign quot      = est2 + ((rem2 >= BPP32) ? 32'd1 : 32'd0);
  assign calc_page = off2 + quot;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        empr_pkg::RK_ACK:      result <= '{status: empr_pkg::ST_OK, volume_page: 32'd0};
        empr_pkg::RK_RESERVED: result <= '{status: empr_pkg::ST_OK, volume_page: RES_PAGE};
        empr_pkg::RK_CALC: begin
          if (miss2) begin
            result <= '{status: empr_pkg::ST_NOT_FOUND, volume_page: 32'd0};
          end else if (range2) begin
            result <= '{status: empr_pkg::ST_RANGE, volume_page: 32'd0};
          end else begin
            result <= '{status: empr_pkg::ST_OK, volume_page: calc_page};
          end
        end
        default: result <= '{status: empr_pkg::ST_NOT_FOUND, volume_page: 32'd0};
      endcase
    end
  end

endmodule

@@ hdl/extent_map_page_resolver.sv @@
// ----------------------------------------------------------------------------
// extent_map_page_resolver
// Resolves logical pages to volume pages through a table of extent entries.
//
// Input: an item is taken at a rising edge with start high and busy low.
// A write item loads one table slot; a lookup item scans the first
// map_count slots, at most TABLE_DEPTH, for the extent holding page_num.
// Output: each result is shown on result for one cycle with done high;
// the receiver cannot stall, so every result is taken in that cycle.
// Config: cfg_valid/cfg_index/cfg_data, always ready; write while idle.
// Flow: a write, or a lookup on an empty map, shows done in the cycle
// after acceptance. A lookup reads one slot per cycle, 1 to map_count slots;
// it then shows done when no slot holds the page, else after the three
// arithmetic stages have formed the page.
// A new item can be taken in the cycle its predecessor's done is high.
// Reset clears the registers to map_count 0 and the default markers; the
// table holds no defined entries until they are written.
// ----------------------------------------------------------------------------
module extent_map_page_resolver #(
  parameter int unsigned TABLE_DEPTH     = 64,
  parameter int unsigned BLOCKS_PER_PAGE = 16,
  parameter int unsigned RESERVED_BLOCKS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  empr_pkg::item_t                item,
  output logic                           done,
  output empr_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [empr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  empr_pkg::ctrl_cmd_t  cmd;
  empr_pkg::dp_status_t stat;

  // registers accept a write beat in any cycle
  assign cfg_ready = 1'b1;

  empr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  empr_dpath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

@@ hdl/empr_checker.sv @@
// ----------------------------------------------------------------------------
// empr_checker
// Port-level checks of the resolver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module empr_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input empr_pkg::result_t result
);

  // a result beat is never shown while an item is still at work
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  // an accepted item either works on or answers in the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item dropped");

  // a result follows an acceptance or the end of work
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an item");

  // only defined status codes, and a page only with ok status
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == empr_pkg::ST_OK || result.status == empr_pkg::ST_NOT_FOUND ||
              result.status == empr_pkg::ST_RANGE))
    else $error("undefined status code");

  a_page_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != empr_pkg::ST_OK) |-> (result.volume_page == 32'd0))
    else $error("page set on a failed lookup");

endmodule

bind extent_map_page_resolver empr_checker u_empr_checker (.*);
